### rtl/afp_pkg.sv
// Shared constants, types and helper functions of the answer frame parser.
// Depends on nothing; the datapath, controller, top level and checker import it.
`default_nettype none

package afp_pkg;

  localparam logic [7:0]  START_BYTE      = 8'h53;
  localparam logic [7:0]  COMMAND_BYTE    = 8'h52;
  localparam logic [15:0] AUX_ADDRESS     = 16'h3008;
  localparam logic [7:0]  AUX_WORDS       = 8'h01;
  localparam logic [15:0] ANSWER_ADDR_RST = 16'h3000;

  localparam int HEADER_BYTES  = 6;
  localparam int PREFIX_BYTES  = HEADER_BYTES - 1;
  localparam int MAX_WORDS_DEF = 6;
  localparam int RESULT_LIMIT  = 8;
  // Width that holds any frame length, header plus up to seven words.
  localparam int FLEN_W        = 5;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // How far the frame buffer moves toward its head in one shift.
  typedef enum logic [2:0] {
    SH_NONE,
    SH_ONE,
    SH_TWO,
    SH_THREE,
    SH_PREFIX
  } shift_t;

  typedef struct packed {
    logic   accept;
    shift_t shift;
    logic   latch_hdr;
    logic   sum_step;
    logic   push_err;
    logic   push_word;
    logic   finish;
  } afp_cmd_t;

  typedef struct packed {
    logic quick_stable;
    logic fill_zero;
    logic buf0_start;
    logic fill_lt_prefix;
    logic hdr_ok;
    logic frame_complete;
    logic sum_done;
    logic sum_good;
    logic room_err;
    logic room_words;
    logic can_push;
    logic word_last;
  } afp_stat_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] frame_address;
    logic [2:0]  word_index;
    logic [15:0] data_word;
  } result_t;

  // True when the four bytes after a start byte form one of the two accepted headers.
  function automatic logic hdr_check(input logic [7:0]  len_byte,
                                     input logic [7:0]  cmd_byte,
                                     input logic [7:0]  adr_lo,
                                     input logic [7:0]  adr_hi,
                                     input logic [15:0] answer_address,
                                     input logic [7:0]  answer_words);
    logic [15:0] adr;
    adr = {adr_hi, adr_lo};
    return (cmd_byte == COMMAND_BYTE) &&
           (((adr == answer_address) && (len_byte == answer_words)) ||
            ((adr == AUX_ADDRESS) && (len_byte == AUX_WORDS)));
  endfunction

  function automatic logic [2:0] shift_amount(input shift_t sh);
    logic [2:0] amt;
    case (sh)
      SH_ONE:    amt = 3'd1;
      SH_TWO:    amt = 3'd2;
      SH_THREE:  amt = 3'd3;
      SH_PREFIX: amt = 3'(PREFIX_BYTES);
      default:   amt = 3'd0;
    endcase
    return amt;
  endfunction

endpackage

`default_nettype wire

### rtl/afp_if.sv
// Valid/ready channel interfaces of the answer frame parser: received bytes in,
// parsed results out. Depends on nothing.
`default_nettype none

interface afp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] frame_address;
  logic [2:0]  word_index;
  logic [15:0] data_word;
  logic        last;

  modport source (output valid, output kind, output frame_address, output word_index,
                  output data_word, output last, input ready);
  modport sink (input valid, input kind, input frame_address, input word_index,
                input data_word, input last, output ready);
endinterface

`default_nettype wire

### rtl/afp_datapath.sv
// Datapath of the answer frame parser: frame buffer, checksum accumulator,
// header registers, pending result and output register. Depends on afp_pkg.
`default_nettype none

module afp_datapath import afp_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [7:0]  in_byte,
  input  afp_cmd_t    cmd,
  output afp_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output logic        out_last
);

  localparam int Depth = HEADER_BYTES + 2 * MAX_WORDS;
  localparam int IdxW  = $clog2(Depth);
  localparam int FillW = $clog2(Depth + 1);

  logic [7:0]       frame_bytes [Depth];
  logic [FillW-1:0] fill_count;
  logic [IdxW-1:0]  sum_idx;
  logic [7:0]       running_sum;
  logic [15:0]      answer_address;
  logic [15:0]      hdr_address;
  logic [2:0]       hdr_words;
  logic [2:0]       word_count;
  logic [3:0]       res_count;
  logic             pend_valid;
  result_t          pend_res;

  logic [FLEN_W-1:0] fill_ext;
  logic [FLEN_W-1:0] flen_scan;
  logic [FLEN_W-1:0] flen_hdr;
  logic              hdr_ok_quick;
  logic              hdr_ok_buf;
  logic              out_free;
  logic              push;
  logic              move;
  logic              buf_full;
  logic              drop_byte;
  logic [2:0]        amt;
  result_t           new_res;

  assign fill_ext  = FLEN_W'(fill_count);
  assign flen_scan = FLEN_W'(HEADER_BYTES) + {1'b0, frame_bytes[1][2:0], 1'b0};
  assign flen_hdr  = FLEN_W'(HEADER_BYTES) + {1'b0, hdr_words, 1'b0};
  assign buf_full  = fill_count == FillW'(Depth);
  assign drop_byte = (fill_count == '0) && (in_byte != START_BYTE);
  assign amt       = shift_amount(cmd.shift);
  assign out_free  = !out_valid || out_ready;
  assign push      = cmd.push_err || cmd.push_word;
  assign move      = pend_valid && (push || cmd.finish);

  // The last header byte may be the one arriving now.
  assign hdr_ok_quick = hdr_check(frame_bytes[1], frame_bytes[2], frame_bytes[3], in_byte,
                                  answer_address, 8'(MAX_WORDS));
  // The header is checked against the current answer address on every byte.
  assign hdr_ok_buf   = hdr_check(frame_bytes[1], frame_bytes[2], frame_bytes[3],
                                  frame_bytes[4], answer_address, 8'(MAX_WORDS));

  always_comb begin
    if (fill_count < FillW'(PREFIX_BYTES - 1)) begin
      stat.quick_stable = 1'b1;
    end else if (fill_count == FillW'(PREFIX_BYTES - 1)) begin
      stat.quick_stable = hdr_ok_quick;
    end else begin
      stat.quick_stable = hdr_ok_buf && ((fill_ext + FLEN_W'(1)) < flen_scan);
    end
    stat.fill_zero      = fill_count == '0;
    stat.buf0_start     = frame_bytes[0] == START_BYTE;
    stat.fill_lt_prefix = fill_count < FillW'(PREFIX_BYTES);
    stat.hdr_ok         = hdr_ok_buf;
    stat.frame_complete = fill_ext >= flen_scan;
    stat.sum_done       = FLEN_W'(sum_idx) == (flen_hdr - FLEN_W'(1));
    stat.sum_good       = running_sum == frame_bytes[sum_idx];
    stat.room_err       = res_count < 4'(RESULT_LIMIT);
    stat.room_words     = (res_count + {1'b0, hdr_words}) <= 4'(RESULT_LIMIT);
    stat.can_push       = !pend_valid || out_free;
    stat.word_last      = word_count == (hdr_words - 3'd1);
  end

  always_comb begin
    if (cmd.push_err) begin
      new_res.kind          = KIND_ERROR;
      new_res.frame_address = hdr_address;
      new_res.word_index    = 3'd0;
      new_res.data_word     = 16'd0;
    end else begin
      new_res.kind          = KIND_DATA;
      new_res.frame_address = hdr_address;
      new_res.word_index    = word_count;
      new_res.data_word     = {frame_bytes[1], frame_bytes[0]};
    end
  end

  // Frame buffer: appends at the fill point, moves toward the head as bytes are consumed.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (buf_full) begin
        for (int k = 0; k < Depth - 1; k++) begin
          frame_bytes[k] <= frame_bytes[k + 1];
        end
        frame_bytes[Depth - 1] <= in_byte;
      end else if (!drop_byte) begin
        frame_bytes[fill_count[IdxW-1:0]] <= in_byte;
      end
    end else begin
      case (cmd.shift)
        SH_ONE: begin
          for (int k = 0; k < Depth - 1; k++) frame_bytes[k] <= frame_bytes[k + 1];
        end
        SH_TWO: begin
          for (int k = 0; k < Depth - 2; k++) frame_bytes[k] <= frame_bytes[k + 2];
        end
        SH_THREE: begin
          for (int k = 0; k < Depth - 3; k++) frame_bytes[k] <= frame_bytes[k + 3];
        end
        SH_PREFIX: begin
          for (int k = 0; k < Depth - PREFIX_BYTES; k++) begin
            frame_bytes[k] <= frame_bytes[k + PREFIX_BYTES];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Header, checksum and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_hdr) begin
      hdr_address <= {frame_bytes[4], frame_bytes[3]};
      hdr_words   <= frame_bytes[1][2:0];
      running_sum <= 8'd0;
      sum_idx     <= '0;
      word_count  <= 3'd0;
    end
    if (cmd.sum_step) begin
      running_sum <= running_sum + frame_bytes[sum_idx];
      sum_idx     <= sum_idx + IdxW'(1);
    end
    if (cmd.push_word) begin
      word_count <= word_count + 3'd1;
    end
    if (push) begin
      pend_res <= new_res;
    end
    if (move) begin
      out_res  <= pend_res;
      out_last <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      res_count      <= 4'd0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
      answer_address <= ANSWER_ADDR_RST;
    end else begin
      if (cfg_we) begin
        answer_address <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (!buf_full && !drop_byte) begin
          fill_count <= fill_count + FillW'(1);
        end
      end else begin
        fill_count <= fill_count - FillW'(amt);
      end
      if (cmd.finish) begin
        res_count  <= 4'd0;
        pend_valid <= 1'b0;
      end else if (push) begin
        res_count  <= res_count + 4'd1;
        pend_valid <= 1'b1;
      end
      out_valid <= move || (out_valid && !out_ready);
    end
  end

endmodule

`default_nettype wire

### rtl/afp_controller.sv
// Sequencing state machine of the answer frame parser: scans the buffer,
// runs the checksum pass and issues results. Depends on afp_pkg.
`default_nettype none

module afp_controller import afp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  afp_stat_t stat,
  output afp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SUM,
    S_WORDS,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!stat.quick_stable) state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.fill_zero) begin
          state_next = S_DONE;
        end else if (!stat.buf0_start) begin
          cmd.shift = SH_ONE;
        end else if (stat.fill_lt_prefix) begin
          state_next = S_DONE;
        end else if (!stat.hdr_ok) begin
          cmd.shift = SH_ONE;
        end else if (!stat.frame_complete) begin
          state_next = S_DONE;
        end else begin
          cmd.latch_hdr = 1'b1;
          state_next    = S_SUM;
        end
      end
      S_SUM: begin
        if (!stat.sum_done) begin
          cmd.sum_step = 1'b1;
        end else if (stat.sum_good) begin
          if (stat.room_words) begin
            cmd.shift  = SH_PREFIX;
            state_next = S_WORDS;
          end else begin
            state_next = S_DONE;
          end
        end else if (!stat.room_err) begin
          state_next = S_DONE;
        end else if (stat.can_push) begin
          cmd.push_err = 1'b1;
          cmd.shift    = SH_ONE;
          state_next   = S_SCAN;
        end
      end
      S_WORDS: begin
        if (stat.can_push) begin
          cmd.push_word = 1'b1;
          if (stat.word_last) begin
            // The checksum byte goes out together with the last word.
            cmd.shift  = SH_THREE;
            state_next = S_SCAN;
          end else begin
            cmd.shift = SH_TWO;
          end
        end
      end
      S_DONE: begin
        if (stat.can_push) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/answer_frame_parser_top.sv
// A byte that neither completes a frame nor breaks a header is taken with no scan.
// A byte that completes a frame holds the input while the buffer is scanned, the L frame
// bytes are summed and compared, and the W words are issued one per cycle unless results
// stall. Bytes dropped while rescanning after a bad header or checksum go one at a time.
// Reset (synchronous, active high) empties the buffer, clears the result path and
// sets answer_address to 0x3000; buffer contents themselves are not cleared.
`default_nettype none

module answer_frame_parser_top import afp_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  afp_byte_if.sink    rx,
  afp_result_if.source res
);

  // The controller walks the buffer one step per cycle unless a result stalls. The datapath holds an
  // eighteen byte frame buffer that only ever shifts toward its head, so every
  // header field sits at a fixed place; one read port walks the checksum.
  //
  // Results are staged one deep before the output register. A result is only
  // known to be the last of its byte when the scan that follows it has ended,
  // so the staged result leaves with last set when the controller finishes.
  //
  // While the controller is idle the buffer either is empty or begins with a
  // start byte. Bytes that leave its header accepted, at the answer or auxiliary
  // address, and its frame incomplete are taken back to back without a scan; a
  // byte arriving into an empty buffer that is not a start byte is discarded
  // right away.

  afp_cmd_t  cmd;
  afp_stat_t stat;
  result_t   out_res;
  logic      out_valid;
  logic      out_last;

  afp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  afp_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (rx.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (res.ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  // Result beat: straight from the output register.
  assign res.valid         = out_valid;
  assign res.kind          = out_res.kind;
  assign res.frame_address = out_res.frame_address;
  assign res.word_index    = out_res.word_index;
  assign res.data_word     = out_res.data_word;
  assign res.last          = out_last;

endmodule

`default_nettype wire

### rtl/afp_checker.sv
// Port-level assertions for the answer frame parser, bound to the top level.
// Depends on afp_pkg and answer_frame_parser_top.
`default_nettype none

module afp_checker import afp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [15:0] frame_address,
  input logic [2:0]  word_index,
  input logic [15:0] data_word,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(frame_address) &&
      $stable(word_index) && $stable(data_word) && $stable(last))
    else $error("stalled result beat changed");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ERROR) |-> (word_index == 3'd0) && (data_word == 16'd0))
    else $error("checksum error beat carries word data");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DATA) |-> (word_index < 3'(MAX_WORDS_DEF)))
    else $error("word index beyond frame size");

endmodule

bind answer_frame_parser_top afp_checker u_afp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .kind          (res.kind),
  .frame_address (res.frame_address),
  .word_index    (res.word_index),
  .data_word     (res.data_word),
  .last          (res.last)
);

`default_nettype wire
